FILE: rtl/j3d_pkg.sv
// ----------------------------------------------------------------------------
// j3d_pkg: shared types, constants and saturating helpers for the 3-D Jacobi
// stencil sweep core.
// ----------------------------------------------------------------------------
package j3d_pkg;

  localparam int unsigned MaxDim    = 16;
  localparam int unsigned DimBits   = $clog2(MaxDim);
  localparam int unsigned AddrBits  = 3 * DimBits;
  localparam int unsigned Depth     = MaxDim * MaxDim * MaxDim;
  localparam int unsigned SizeBits  = 5;
  localparam int unsigned ValBits   = 64;
  localparam int unsigned FracBits  = 32;
  localparam int unsigned CoefBits  = 63;
  localparam int unsigned HalfBits  = 32;
  localparam int unsigned AccBits   = 2 * ValBits;

  localparam logic [ValBits-1:0] ValMax = {1'b0, {(ValBits-1){1'b1}}};
  localparam logic [ValBits-1:0] ValMin = {1'b1, {(ValBits-1){1'b0}}};

  // configuration register indexes
  localparam logic [2:0] RegSizeX  = 3'd0;
  localparam logic [2:0] RegSizeY  = 3'd1;
  localparam logic [2:0] RegSizeZ  = 3'd2;
  localparam logic [2:0] RegCoefX  = 3'd3;
  localparam logic [2:0] RegCoefY  = 3'd4;
  localparam logic [2:0] RegCoefZ  = 3'd5;
  localparam logic [2:0] RegScale  = 3'd6;
  localparam logic [2:0] RegTol    = 3'd7;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SWEEP = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_PREP,
    ST_MUL,
    ST_ROUND,
    ST_WRITE,
    ST_MAX,
    ST_DONE
  } state_e;

  function automatic logic [ValBits-1:0] sat_add(logic [ValBits-1:0] a,
                                                 logic [ValBits-1:0] b);
    logic [ValBits:0] s;
    s = {a[ValBits-1], a} + {b[ValBits-1], b};
    if (s[ValBits] != s[ValBits-1]) begin
      return s[ValBits] ? ValMin : ValMax;
    end
    return s[ValBits-1:0];
  endfunction

  function automatic logic [ValBits-1:0] sat_sub(logic [ValBits-1:0] a,
                                                 logic [ValBits-1:0] b);
    logic [ValBits:0] s;
    s = {a[ValBits-1], a} - {b[ValBits-1], b};
    if (s[ValBits] != s[ValBits-1]) begin
      return s[ValBits] ? ValMin : ValMax;
    end
    return s[ValBits-1:0];
  endfunction

  // clamp a configured size to the grid dimension
  function automatic logic [SizeBits-1:0] lim(logic [SizeBits-1:0] s);
    if (s > SizeBits'(MaxDim)) begin
      return SizeBits'(MaxDim);
    end
    return s;
  endfunction

endpackage

FILE: rtl/jacobi_3d_stencil_sweep_core.sv
// ----------------------------------------------------------------------------
// jacobi_3d_stencil_sweep_core: 7-point Jacobi sweep over a 16^3 grid
// Load writes the stores in the idle state; a read passes through ST_READ, then the
// word waits in the output register. For each interior point a sweep fetches the
// six neighbors and the center through the one grid read port, then runs four
// Q32.32 products on one shared 32x32 multiplier, then writes the other store.
// One word is processed at a time; the next is taken once the result is gone.
// Reset selects the even store and loads the default registers; the grid and
// source stores are undefined until loaded.
// ----------------------------------------------------------------------------
module jacobi_3d_stencil_sweep_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  x_index_i,
  input  logic [3:0]  y_index_i,
  input  logic [3:0]  z_index_i,
  input  logic [63:0] point_value_i,
  input  logic [63:0] source_term_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_value_o,
  output logic [62:0] max_change_o,
  output logic        converged_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned AW = j3d_pkg::AddrBits;
  localparam int unsigned VW = j3d_pkg::ValBits;
  localparam int unsigned SW = j3d_pkg::SizeBits;
  localparam int unsigned DW = j3d_pkg::DimBits;
  localparam int unsigned CW = j3d_pkg::CoefBits;
  localparam int unsigned HW = j3d_pkg::HalfBits;
  localparam int unsigned ACW = j3d_pkg::AccBits;
  localparam int unsigned FB = j3d_pkg::FracBits;

  // configuration registers
  logic [SW-1:0] size_x_q, size_y_q, size_z_q;
  logic [CW-1:0] coef_x_q, coef_y_q, coef_z_q, scale_q, tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SW'(16);
      size_y_q <= SW'(16);
      size_z_q <= SW'(16);
      coef_x_q <= CW'(64'd241591910400);
      coef_y_q <= CW'(64'd241591910400);
      coef_z_q <= CW'(64'd241591910400);
      scale_q  <= CW'(64'd42805);
      tol_q    <= CW'(64'd43);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        j3d_pkg::RegSizeX: size_x_q <= cfg_data_i[SW-1:0];
        j3d_pkg::RegSizeY: size_y_q <= cfg_data_i[SW-1:0];
        j3d_pkg::RegSizeZ: size_z_q <= cfg_data_i[SW-1:0];
        j3d_pkg::RegCoefX: coef_x_q <= cfg_data_i[CW-1:0];
        j3d_pkg::RegCoefY: coef_y_q <= cfg_data_i[CW-1:0];
        j3d_pkg::RegCoefZ: coef_z_q <= cfg_data_i[CW-1:0];
        j3d_pkg::RegScale: scale_q  <= cfg_data_i[CW-1:0];
        j3d_pkg::RegTol:   tol_q    <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // stores: two ping-pong grids and the source term, with registered read data
  logic [VW-1:0] even_mem [j3d_pkg::Depth];
  logic [VW-1:0] odd_mem  [j3d_pkg::Depth];
  logic [VW-1:0] src_mem  [j3d_pkg::Depth];

  logic [AW-1:0] raddr, waddr;
  logic [VW-1:0] wdata, wsrc;
  logic          we_even, we_odd, we_src;
  logic [VW-1:0] even_rd_q, odd_rd_q, src_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_even) begin
      even_mem[waddr] <= wdata;
    end
    even_rd_q <= even_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      odd_mem[waddr] <= wdata;
    end
    odd_rd_q <= odd_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_src) begin
      src_mem[waddr] <= wsrc;
    end
    src_rd_q <= src_mem[raddr];
  end

  // sequencer and datapath state
  j3d_pkg::state_e state_q, state_d;
  logic          cur_q, cur_d;
  logic [2:0]    step_q, step_d;
  logic [1:0]    term_q, term_d;
  logic [DW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [VW-1:0] nb_q [7];
  logic [VW-1:0] nb_d [7];
  logic [VW-1:0] src_q, src_d;
  logic [VW-1:0] mag_q, mag_d;
  logic          neg_q, neg_d;
  logic [ACW-1:0] acc_q, acc_d;
  logic [VW-1:0] sum_q, sum_d, nv_q, nv_d, diff_q, diff_d, worst_q, worst_d;
  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] rv_q, rv_d;
  logic [CW-1:0] mc_q, mc_d;
  logic          cv_q, cv_d;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign max_change_o = mc_q;
  assign converged_o  = cv_q;
  assign in_stall_o   = (state_q != j3d_pkg::ST_IDLE) || out_valid_q;

  logic [SW-1:0] nx, ny, nz;
  assign nx = j3d_pkg::lim(size_x_q);
  assign ny = j3d_pkg::lim(size_y_q);
  assign nz = j3d_pkg::lim(size_z_q);

  logic [VW-1:0] rd_cur;
  assign rd_cur = cur_q ? odd_rd_q : even_rd_q;

  // shared 32x32 multiplier, one partial product per cycle
  logic [CW-1:0] coef_sel;
  logic [HW-1:0] mul_a, mul_b;
  logic [2*HW-1:0] pp;
  logic [ACW-1:0] pp_sh;

  always_comb begin
    unique case (term_q)
      2'd0: coef_sel = coef_x_q;
      2'd1: coef_sel = coef_y_q;
      2'd2: coef_sel = coef_z_q;
      default: coef_sel = scale_q;
    endcase
    mul_a = step_q[1] ? HW'({1'b0, coef_sel[CW-1:HW]}) : coef_sel[HW-1:0];
    mul_b = step_q[0] ? mag_q[VW-1:HW] : mag_q[HW-1:0];
    pp    = mul_a * mul_b;
    pp_sh = ACW'(pp) << (HW * (32'(step_q[1]) + 32'(step_q[0])));
  end

  // round-to-nearest already folded in by the half preset of the accumulator
  logic [VW-1:0] qlo, limit, qsat, prod_res;
  always_comb begin
    qlo   = acc_q[FB+VW-1:FB];
    limit = j3d_pkg::ValMax + VW'(neg_q);
    qsat  = ((|acc_q[ACW-1:FB+VW]) || (qlo > limit)) ? limit : qlo;
    prod_res = neg_q ? (~qsat + VW'(1)) : qsat;
  end

  logic [VW-1:0] prep_val;
  logic [SW-1:0] z_ext, y_ext, x_ext;
  logic          last_z, last_y, last_x, empty_grid;
  logic [AW-1:0] ctr_addr;

  always_comb begin
    unique case (term_q)
      2'd0: prep_val = j3d_pkg::sat_add(nb_q[0], nb_q[1]);
      2'd1: prep_val = j3d_pkg::sat_add(nb_q[2], nb_q[3]);
      2'd2: prep_val = j3d_pkg::sat_add(nb_q[4], nb_q[5]);
      default: prep_val = j3d_pkg::sat_sub(sum_q, src_q);
    endcase
    z_ext  = SW'(z_q) + SW'(2);
    y_ext  = SW'(y_q) + SW'(2);
    x_ext  = SW'(x_q) + SW'(2);
    last_z = z_ext >= nz;
    last_y = y_ext >= ny;
    last_x = x_ext >= nx;
    empty_grid = (nx < SW'(3)) || (ny < SW'(3)) || (nz < SW'(3));
    ctr_addr = {x_q, y_q, z_q};
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    step_d  = step_q;
    term_d  = term_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    nb_d    = nb_q;
    src_d   = src_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    nv_d    = nv_q;
    diff_d  = diff_q;
    worst_d = worst_q;
    out_valid_d = out_valid_q;
    rv_d = rv_q; mc_d = mc_q; cv_d = cv_q;
    raddr   = {x_index_i, y_index_i, z_index_i};
    waddr   = {x_index_i, y_index_i, z_index_i};
    wdata   = point_value_i;
    wsrc    = source_term_i;
    we_even = 1'b0;
    we_odd  = 1'b0;
    we_src  = 1'b0;

    // drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      j3d_pkg::ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          rv_d = '0; mc_d = '0; cv_d = 1'b0;
          unique case (kind_i)
            j3d_pkg::KIND_LOAD: begin
              we_even = 1'b1;
              we_odd  = 1'b1;
              we_src  = 1'b1;
              out_valid_d = 1'b1;
            end
            j3d_pkg::KIND_SWEEP: begin
              worst_d = '0;
              if (empty_grid) begin
                cur_d = ~cur_q;
                cv_d  = tol_q != '0;
                out_valid_d = 1'b1;
              end else begin
                x_d = DW'(1); y_d = DW'(1); z_d = DW'(1);
                step_d  = '0;
                state_d = j3d_pkg::ST_FETCH;
              end
            end
            j3d_pkg::KIND_READ: state_d = j3d_pkg::ST_READ;
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      j3d_pkg::ST_READ: begin
        rv_d = rd_cur;
        out_valid_d = 1'b1;
        state_d = j3d_pkg::ST_IDLE;
      end
      j3d_pkg::ST_FETCH: begin
        // issue neighbor and center reads, capture each in the next cycle
        unique case (step_q)
          3'd0: raddr = {x_q + DW'(1), y_q, z_q};
          3'd1: raddr = {x_q - DW'(1), y_q, z_q};
          3'd2: raddr = {x_q, y_q + DW'(1), z_q};
          3'd3: raddr = {x_q, y_q - DW'(1), z_q};
          3'd4: raddr = {x_q, y_q, z_q + DW'(1)};
          3'd5: raddr = {x_q, y_q, z_q - DW'(1)};
          default: raddr = ctr_addr;
        endcase
        if (step_q != 3'd0) begin
          nb_d[step_q - 3'd1] = rd_cur;
        end
        if (step_q == 3'd7) begin
          src_d   = src_rd_q;
          term_d  = 2'd0;
          state_d = j3d_pkg::ST_PREP;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      j3d_pkg::ST_PREP: begin
        neg_d  = prep_val[VW-1];
        mag_d  = prep_val[VW-1] ? (~prep_val + VW'(1)) : prep_val;
        acc_d  = ACW'(1) << (FB - 1);
        step_d = '0;
        state_d = j3d_pkg::ST_MUL;
      end
      j3d_pkg::ST_MUL: begin
        acc_d = acc_q + pp_sh;
        if (step_q == 3'd3) begin
          state_d = j3d_pkg::ST_ROUND;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      j3d_pkg::ST_ROUND: begin
        unique case (term_q)
          2'd0: sum_d = prod_res;
          2'd1, 2'd2: sum_d = j3d_pkg::sat_add(sum_q, prod_res);
          default: nv_d = prod_res;
        endcase
        if (term_q == 2'd3) begin
          state_d = j3d_pkg::ST_WRITE;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = j3d_pkg::ST_PREP;
        end
      end
      j3d_pkg::ST_WRITE: begin
        // write the new value into the other store
        waddr   = ctr_addr;
        wdata   = nv_q;
        we_even = cur_q;
        we_odd  = ~cur_q;
        diff_d  = ($signed(nv_q) >= $signed(nb_q[6])) ? (nv_q - nb_q[6])
                                                      : (nb_q[6] - nv_q);
        state_d = j3d_pkg::ST_MAX;
      end
      j3d_pkg::ST_MAX: begin
        if (diff_q > worst_q) begin
          worst_d = diff_q;
        end
        step_d  = '0;
        state_d = j3d_pkg::ST_FETCH;
        // advance z fastest, then y, then x
        if (!last_z) begin
          z_d = z_q + DW'(1);
        end else begin
          z_d = DW'(1);
          if (!last_y) begin
            y_d = y_q + DW'(1);
          end else begin
            y_d = DW'(1);
            if (!last_x) begin
              x_d = x_q + DW'(1);
            end else begin
              state_d = j3d_pkg::ST_DONE;
            end
          end
        end
      end
      j3d_pkg::ST_DONE: begin
        cur_d = ~cur_q;
        mc_d  = worst_q[VW-1] ? {CW{1'b1}} : worst_q[CW-1:0];
        cv_d  = worst_q < VW'(tol_q);
        out_valid_d = 1'b1;
        state_d = j3d_pkg::ST_IDLE;
      end
      default: state_d = j3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= j3d_pkg::ST_IDLE;
      cur_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      term_q      <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      term_q      <= term_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    nb_q    <= nb_d;
    src_q   <= src_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
    nv_q    <= nv_d;
    diff_q  <= diff_d;
    worst_q <= worst_d;
    rv_q    <= rv_d;
    mc_q    <= mc_d;
    cv_q    <= cv_d;
  end

endmodule
